// ===== src/blpg_pkg.sv =====
// Shared types and constants for the line pixel generator.
`timescale 1ns / 1ps
package blpg_pkg;

    localparam int DEFAULT_SCREEN_WIDTH  = 240;
    localparam int DEFAULT_SCREEN_HEIGHT = 135;
    localparam int DEFAULT_QUEUE_DEPTH   = 2;
    localparam int STEPS_PER_GROUP       = 4;
    localparam int MAX_GROUPS            = 64;
    localparam int GCNT_W                = $clog2(MAX_GROUPS);
    localparam int ERR_W                 = 11;

    typedef struct packed {
        logic [7:0]  start_x;
        logic [7:0]  start_y;
        logic [7:0]  end_x;
        logic [7:0]  end_y;
        logic [23:0] color_rgb;
    } t_line_req;

    typedef struct packed {
        logic [7:0]  step0_x;
        logic [7:0]  step0_y;
        logic [7:0]  step1_x;
        logic [7:0]  step1_y;
        logic [7:0]  step2_x;
        logic [7:0]  step2_y;
        logic [7:0]  step3_x;
        logic [7:0]  step3_y;
        logic [3:0]  visible_mask;
        logic [15:0] color_565;
        logic        last_group;
    } t_pixel_group;

    typedef struct packed {
        logic [7:0]              x0;
        logic [7:0]              y0;
        logic [7:0]              x1;
        logic [7:0]              y1;
        logic [7:0]              dx;
        logic [7:0]              dy;
        logic                    sx_neg;
        logic                    sy_neg;
        logic signed [ERR_W-1:0] err0;
        logic [15:0]             color_565;
    } t_job;

endpackage

// ===== src/blpg_front.sv =====
// Front end: accepts line requests and turns them into walk jobs.
`timescale 1ns / 1ps
module blpg_front (
    input  logic              start,
    output logic              busy,
    input  blpg_pkg::t_line_req i_req,
    input  logic              i_full,
    output logic              o_push,
    output blpg_pkg::t_job    o_job
);
    import blpg_pkg::*;

    logic [7:0] dx;
    logic [7:0] dy;

    assign busy   = i_full;
    assign o_push = start && !i_full;

    assign dx = (i_req.end_x > i_req.start_x) ? i_req.end_x - i_req.start_x
                                              : i_req.start_x - i_req.end_x;
    assign dy = (i_req.end_y > i_req.start_y) ? i_req.end_y - i_req.start_y
                                              : i_req.start_y - i_req.end_y;

    always_comb begin
        o_job.x0        = i_req.start_x;
        o_job.y0        = i_req.start_y;
        o_job.x1        = i_req.end_x;
        o_job.y1        = i_req.end_y;
        o_job.dx        = dx;
        o_job.dy        = dy;
        o_job.sx_neg    = !(i_req.start_x < i_req.end_x);
        o_job.sy_neg    = !(i_req.start_y < i_req.end_y);
        o_job.err0      = $signed({{(ERR_W-8){1'b0}}, dx})
                        - $signed({{(ERR_W-8){1'b0}}, dy});
        o_job.color_565 = {i_req.color_rgb[23:19], i_req.color_rgb[15:10],
                           i_req.color_rgb[7:3]};
    end

endmodule

// ===== src/blpg_queue.sv =====
// Short job queue between the front end and the line walker.
`timescale 1ns / 1ps
module blpg_queue #(
    parameter int DEPTH = blpg_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  blpg_pkg::t_job i_job,
    input  logic           i_pop,
    output blpg_pkg::t_job o_job,
    output logic           o_empty,
    output logic           o_full
);
    import blpg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            case ({i_push && !o_full, i_pop && !o_empty})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/blpg_back.sv =====
// Back end: walks the line four steps per cycle and emits pixel groups.
`timescale 1ns / 1ps
module blpg_back #(
    parameter int SCREEN_WIDTH  = blpg_pkg::DEFAULT_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = blpg_pkg::DEFAULT_SCREEN_HEIGHT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  blpg_pkg::t_job         i_job,
    input  logic                   i_empty,
    output logic                   o_pop,
    output logic                   o_valid,
    output blpg_pkg::t_pixel_group o_group
);
    import blpg_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                    r_state;
    t_job                    r_job;
    logic [7:0]              r_x;
    logic [7:0]              r_y;
    logic signed [ERR_W-1:0] r_err;
    logic [GCNT_W-1:0]       r_gcnt;
    logic                    r_valid;
    t_pixel_group            r_group;

    logic                    n_state;
    logic [7:0]              cx;
    logic [7:0]              cy;
    logic signed [ERR_W-1:0] cerr;
    logic signed [ERR_W:0]   e2;
    logic signed [ERR_W:0]   dx_w;
    logic signed [ERR_W:0]   dy_w;
    logic                    done;
    logic [3:0]              mask;
    logic [7:0]              xs [STEPS_PER_GROUP];
    logic [7:0]              ys [STEPS_PER_GROUP];
    t_pixel_group            n_group;

    assign o_pop   = (r_state == ST_IDLE) && !i_empty;
    assign o_valid = r_valid;
    assign o_group = r_group;

    assign dx_w = $signed({{(ERR_W-7){1'b0}}, r_job.dx});
    assign dy_w = -$signed({{(ERR_W-7){1'b0}}, r_job.dy});

    always_comb begin
        cx   = r_x;
        cy   = r_y;
        cerr = r_err;
        done = 1'b0;
        mask = '0;
        e2   = '0;
        for (int i = 0; i < STEPS_PER_GROUP; i++) begin
            xs[i] = '0;
            ys[i] = '0;
            if (!done) begin
                xs[i]   = cx;
                ys[i]   = cy;
                mask[i] = ({1'b0, cx} < 9'(SCREEN_WIDTH))
                       && ({1'b0, cy} < 9'(SCREEN_HEIGHT));
                if ((cx == r_job.x1 && cy == r_job.y1)
                        || (r_gcnt == GCNT_W'(MAX_GROUPS - 1)
                            && i == STEPS_PER_GROUP - 1)) begin
                    done = 1'b1;
                end else begin
                    e2 = {cerr, 1'b0};
                    if (e2 >= dy_w) begin
                        cerr = cerr + dy_w[ERR_W-1:0];
                        cx   = r_job.sx_neg ? cx - 8'd1 : cx + 8'd1;
                    end
                    if (e2 <= dx_w) begin
                        cerr = cerr + dx_w[ERR_W-1:0];
                        cy   = r_job.sy_neg ? cy - 8'd1 : cy + 8'd1;
                    end
                end
            end
        end
        n_group.step0_x      = xs[0];
        n_group.step0_y      = ys[0];
        n_group.step1_x      = xs[1];
        n_group.step1_y      = ys[1];
        n_group.step2_x      = xs[2];
        n_group.step2_y      = ys[2];
        n_group.step3_x      = xs[3];
        n_group.step3_y      = ys[3];
        n_group.visible_mask = mask;
        n_group.color_565    = r_job.color_565;
        n_group.last_group   = done;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_x   <= i_job.x0;
            r_y   <= i_job.y0;
            r_err <= i_job.err0;
        end else if (r_state == ST_RUN) begin
            r_x   <= cx;
            r_y   <= cy;
            r_err <= cerr;
        end
        r_group <= n_group;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_gcnt  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_RUN);
            if (o_pop) begin
                r_gcnt <= '0;
            end else if (r_state == ST_RUN) begin
                r_gcnt <= r_gcnt + GCNT_W'(1);
            end
        end
    end

endmodule

// ===== src/bresenham_line_pixel_generator_top.sv =====
// Top level of the Bresenham line pixel generator.
`timescale 1ns / 1ps
// A line request is taken when start is high and busy is low. The walker emits
// one group of four steps per clock while walking, so a line of N = max(|dx|,
// |dy|) + 1 steps gives ceil(N / 4) groups, 1 to 64. Before each line it loads
// its job from the queue while idle; a request passes the queue write, job load
// and output register before its first group appears. Requests wait in a job
// queue of QUEUE_DEPTH entries (two by default); busy is high only when full.
// Each group is shown for exactly one cycle with o_valid high; the receiver
// cannot stall the output, so it must take every group as it comes.
module bresenham_line_pixel_generator_top #(
    parameter int SCREEN_WIDTH  = blpg_pkg::DEFAULT_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = blpg_pkg::DEFAULT_SCREEN_HEIGHT,
    parameter int QUEUE_DEPTH   = blpg_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  blpg_pkg::t_line_req    i_req,
    output logic                   o_valid,
    output blpg_pkg::t_pixel_group o_group
);
    import blpg_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_job front_job;
    t_job back_job;

    blpg_front u_front (
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .i_full (full),
        .o_push (push),
        .o_job  (front_job)
    );

    blpg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (back_job),
        .o_empty (empty),
        .o_full  (full)
    );

    blpg_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (back_job),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_group (o_group)
    );

endmodule
